FILE: sv/edgt_pkg.sv
// Package for the envelope detector with gain tracking.
// Holds field widths, register indexes, reset values and filter coefficients.
// No dependencies; every other file of the block imports it.
`default_nettype none

package edgt_pkg;

  // Field widths of the transactions.
  localparam int SAMPLE_W   = 12;
  localparam int ENV_W      = 12;
  localparam int GAIN_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Register widths.
  localparam int POLE_W   = 12;
  localparam int TARGET_W = 13;
  localparam int GMAX_W   = 12;
  localparam int STEP_W   = 8;

  // Internal datapath widths.
  localparam int DC_Y_W     = 16;  // stored DC blocker output
  localparam int DC_ACC_W   = 29;  // DC blocker accumulator
  localparam int DC_Q_W     = DC_ACC_W - 12;
  localparam int LEVEL_W    = 14;  // rectified level
  localparam int FILT_Y_W   = 20;  // stored filter output
  localparam int FILT_ACC_W = 33;  // filter accumulator
  localparam int FILT_Q_W   = FILT_ACC_W - 12;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_POLE        = 3'd0,
    CFG_AGC_TARGET     = 3'd1,
    CFG_GAIN_MAX       = 3'd2,
    CFG_GAIN_UP_STEP   = 3'd3,
    CFG_GAIN_DOWN_STEP = 3'd4
  } cfg_idx_t;

  // Reset values of the registers and of the gain state.
  localparam logic [POLE_W-1:0]   DC_POLE_RST        = 12'd4000;
  localparam logic [TARGET_W-1:0] AGC_TARGET_RST     = 13'd2000;
  localparam logic [GMAX_W-1:0]   GAIN_MAX_RST       = 12'd3000;
  localparam logic [STEP_W-1:0]   GAIN_UP_STEP_RST   = 8'd1;
  localparam logic [STEP_W-1:0]   GAIN_DOWN_STEP_RST = 8'd16;
  localparam logic [GAIN_W-1:0]   GAIN_RST           = 13'd255;

  // DC blocker feed-forward coefficient.
  localparam logic signed [12:0] DC_FF = 13'sd4095;

  // Butterworth low-pass coefficients in Q12.
  localparam logic signed [12:0] B0 = 13'sd493;
  localparam logic signed [12:0] B1 = 13'sd1970;
  localparam logic signed [12:0] B2 = 13'sd2955;
  localparam logic signed [12:0] A0 = -13'sd80;
  localparam logic signed [12:0] A1 = -13'sd279;
  localparam logic signed [12:0] A2 = -13'sd2122;
  localparam logic signed [12:0] A3 = -13'sd1304;

  // Gain tracker settings handed from the register bank.
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [GMAX_W-1:0]   gain_max;
    logic [STEP_W-1:0]   up_step;
    logic [STEP_W-1:0]   down_step;
  } agc_cfg_t;

endpackage

`default_nettype wire

FILE: sv/edgt_in_if.sv
// Input sample channel of the envelope detector.
// Depends on edgt_pkg for the sample width.
`default_nettype none

interface edgt_in_if;
  import edgt_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: sv/edgt_out_if.sv
// Result channel of the envelope detector.
// Depends on edgt_pkg for the field widths.
`default_nettype none

interface edgt_out_if;
  import edgt_pkg::*;

  logic              valid;
  logic              ready;
  logic [ENV_W-1:0]  envelope;
  logic [GAIN_W-1:0] gain_level;
  logic              gain_rising;

  modport source (output valid, output envelope, output gain_level, output gain_rising,
                  input ready);
  modport sink   (input valid, input envelope, input gain_level, input gain_rising,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/edgt_cfg_if.sv
// Register write channel of the envelope detector.
// Depends on edgt_pkg for the index and data widths.
`default_nettype none

interface edgt_cfg_if;
  import edgt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/edgt_dc_blocker.sv
// One-pole DC blocking high-pass followed by a saturating rectifier.
// Depends on edgt_pkg for widths and the feed-forward coefficient.
`default_nettype none

module edgt_dc_blocker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [edgt_pkg::SAMPLE_W-1:0]  sample,
  input  logic [edgt_pkg::POLE_W-1:0]    pole,
  output logic [edgt_pkg::LEVEL_W-1:0]   level
);
  import edgt_pkg::*;

  logic        [SAMPLE_W-1:0] prev_in_r;
  logic signed [DC_Y_W-1:0]   prev_out_r;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [DC_ACC_W-1:0] acc;
  logic signed [DC_Q_W-1:0]   q;
  logic signed [DC_Y_W-1:0]   y;
  logic signed [DC_Y_W:0]     y_e;
  logic        [DC_Y_W:0]     mag;

  // Feed-forward difference times 4095 plus pole times the previous output.
  always_comb begin
    diff = $signed({1'b0, sample}) - $signed({1'b0, prev_in_r});
    acc  = DC_ACC_W'(DC_FF) * DC_ACC_W'(diff)
         + DC_ACC_W'($signed({1'b0, pole})) * DC_ACC_W'(prev_out_r);
    q    = DC_Q_W'(acc >>> 12);
  end

  // Saturate the blocker output to its stored width.
  always_comb begin
    if (q > DC_Q_W'(32767)) begin
      y = {1'b0, {(DC_Y_W-1){1'b1}}};
    end else if (q < -DC_Q_W'(32768)) begin
      y = {1'b1, {(DC_Y_W-1){1'b0}}};
    end else begin
      y = DC_Y_W'(q);
    end
  end

  // Rectify and saturate to the width of the filter input history.
  always_comb begin
    y_e = (DC_Y_W+1)'(y);
    mag = y[DC_Y_W-1] ? (DC_Y_W+1)'(-y_e) : (DC_Y_W+1)'(y_e);
    if (mag > (DC_Y_W+1)'({LEVEL_W{1'b1}})) begin
      level = {LEVEL_W{1'b1}};
    end else begin
      level = LEVEL_W'(mag);
    end
  end

  // Blocker state advances once per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_in_r  <= '0;
      prev_out_r <= '0;
    end else if (en) begin
      prev_in_r  <= sample;
      prev_out_r <= y;
    end
  end

endmodule

`default_nettype wire

FILE: sv/edgt_gain_tracker.sv
// Gain tracker: steps the gain up or down by comparing the level with a target.
// Depends on edgt_pkg for widths, the settings struct and the gain reset value.
`default_nettype none

module edgt_gain_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [edgt_pkg::LEVEL_W-1:0]  level,
  input  edgt_pkg::agc_cfg_t            cfg,
  output logic [edgt_pkg::GAIN_W-1:0]   gain_nxt,
  output logic                          rising_nxt
);
  import edgt_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic              rising_r;

  // Raise below target while under the maximum, else lower while above the step.
  always_comb begin
    gain_nxt   = gain_r;
    rising_nxt = rising_r;
    if (level < LEVEL_W'(cfg.target)) begin
      if (gain_r < GAIN_W'(cfg.gain_max)) begin
        gain_nxt   = gain_r + GAIN_W'(cfg.up_step);
        rising_nxt = 1'b1;
      end
    end else begin
      if (gain_r > GAIN_W'(cfg.down_step)) begin
        gain_nxt   = gain_r - GAIN_W'(cfg.down_step);
        rising_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      rising_r <= 1'b0;
    end else if (en) begin
      gain_r   <= gain_nxt;
      rising_r <= rising_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/edgt_bw_filter.sv
// Fourth-order Butterworth low-pass in Q12 with saturation and output clamp.
// Depends on edgt_pkg for widths and coefficients.
`default_nettype none

module edgt_bw_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [edgt_pkg::LEVEL_W-1:0]  level,
  output logic [edgt_pkg::ENV_W-1:0]    envelope
);
  import edgt_pkg::*;

  logic        [LEVEL_W-1:0]  xh_r [5];
  logic signed [FILT_Y_W-1:0] yh_r [4];

  logic signed [FILT_ACC_W-1:0] xe [5];
  logic signed [FILT_ACC_W-1:0] ye [4];
  logic signed [FILT_ACC_W-1:0] acc;
  logic signed [FILT_Q_W-1:0]   q;
  logic signed [FILT_Y_W-1:0]   f;

  // Extend the history taps to the accumulator width.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      xe[i] = FILT_ACC_W'($signed({1'b0, xh_r[i]}));
    end
    for (int i = 0; i < 4; i++) begin
      ye[i] = FILT_ACC_W'(yh_r[i]);
    end
  end

  // The output uses only the history held before this transaction's level.
  always_comb begin
    acc = FILT_ACC_W'(B0) * (xe[0] + xe[4])
        + FILT_ACC_W'(B1) * (xe[1] + xe[3])
        + FILT_ACC_W'(B2) * xe[2]
        + FILT_ACC_W'(A0) * ye[0]
        + FILT_ACC_W'(A1) * ye[1]
        + FILT_ACC_W'(A2) * ye[2]
        + FILT_ACC_W'(A3) * ye[3];
    q = FILT_Q_W'(acc >>> 12);
  end

  // Saturate to the stored width, then clamp the reported envelope.
  always_comb begin
    if (q > FILT_Q_W'(524287)) begin
      f = {1'b0, {(FILT_Y_W-1){1'b1}}};
    end else if (q < -FILT_Q_W'(524288)) begin
      f = {1'b1, {(FILT_Y_W-1){1'b0}}};
    end else begin
      f = FILT_Y_W'(q);
    end
    if (f[FILT_Y_W-1]) begin
      envelope = '0;
    end else if (f > FILT_Y_W'({ENV_W{1'b1}})) begin
      envelope = {ENV_W{1'b1}};
    end else begin
      envelope = ENV_W'(f);
    end
  end

  // Shift both histories; the new level enters after the output is formed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 5; i++) xh_r[i] <= '0;
      for (int i = 0; i < 4; i++) yh_r[i] <= '0;
    end else if (en) begin
      for (int i = 0; i < 4; i++) xh_r[i] <= xh_r[i+1];
      xh_r[4] <= level;
      for (int i = 0; i < 3; i++) yh_r[i] <= yh_r[i+1];
      yh_r[3] <= f;
    end
  end

endmodule

`default_nettype wire

FILE: sv/envelope_detector_with_gain_tracking_top.sv
// Top level of the envelope detector with gain tracking.
// Depends on edgt_pkg, the three channel interfaces and the three datapath modules.
//
// Each sample transaction produces exactly one result transaction carrying the
// clamped envelope, the updated gain and the gain direction flag. The block takes
// one sample per clock cycle while the result side keeps up; a sample is held in
// the input register and its result in the result register. The DC blocker, gain
// tracker and filter recursions all close combinationally between those two
// registers. The input register keeps taking one sample while a result waits
// downstream. The gain is tracked and reported only; it is not applied to the
// signal. Register writes are taken at any time (ready stays high) and must only
// be issued while the block holds no sample; unknown indexes are ignored.
`default_nettype none

module envelope_detector_with_gain_tracking_top (
  input  logic    clk,
  input  logic    rst_n,
  edgt_in_if.sink   in_ch,
  edgt_out_if.source out_ch,
  edgt_cfg_if.sink  cfg_ch
);
  import edgt_pkg::*;

  // Register bank.
  logic [POLE_W-1:0]   dc_pole_r;
  logic [TARGET_W-1:0] agc_target_r;
  logic [GMAX_W-1:0]   gain_max_r;
  logic [STEP_W-1:0]   gain_up_step_r;
  logic [STEP_W-1:0]   gain_down_step_r;

  // Input register and result register.
  logic                in_valid_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                out_valid_r;
  logic [ENV_W-1:0]    envelope_r;
  logic [GAIN_W-1:0]   gain_level_r;
  logic                gain_rising_r;

  logic                advance;
  logic [LEVEL_W-1:0]  level;
  logic [ENV_W-1:0]    envelope;
  logic [GAIN_W-1:0]   gain_nxt;
  logic                rising_nxt;
  agc_cfg_t            agc_cfg;

  // Register writes are always accepted.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_pole_r        <= DC_POLE_RST;
      agc_target_r     <= AGC_TARGET_RST;
      gain_max_r       <= GAIN_MAX_RST;
      gain_up_step_r   <= GAIN_UP_STEP_RST;
      gain_down_step_r <= GAIN_DOWN_STEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DC_POLE:        dc_pole_r        <= POLE_W'(cfg_ch.data);
        CFG_AGC_TARGET:     agc_target_r     <= TARGET_W'(cfg_ch.data);
        CFG_GAIN_MAX:       gain_max_r       <= GMAX_W'(cfg_ch.data);
        CFG_GAIN_UP_STEP:   gain_up_step_r   <= STEP_W'(cfg_ch.data);
        CFG_GAIN_DOWN_STEP: gain_down_step_r <= STEP_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  assign agc_cfg = '{target:    agc_target_r,
                     gain_max:  gain_max_r,
                     up_step:   gain_up_step_r,
                     down_step: gain_down_step_r};

  // A held sample moves on when the result register is free or being emptied.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r <= in_ch.sample;
    end
  end

  // Datapath between the input register and the result register.
  edgt_dc_blocker u_dc (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .sample (sample_r),
    .pole   (dc_pole_r),
    .level  (level)
  );

  edgt_gain_tracker u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .level      (level),
    .cfg        (agc_cfg),
    .gain_nxt   (gain_nxt),
    .rising_nxt (rising_nxt)
  );

  edgt_bw_filter u_filt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .level    (level),
    .envelope (envelope)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      envelope_r    <= envelope;
      gain_level_r  <= gain_nxt;
      gain_rising_r <= rising_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.envelope    = envelope_r;
  assign out_ch.gain_level  = gain_level_r;
  assign out_ch.gain_rising = gain_rising_r;

  // A sample moved into the datapath always shows up as a result next cycle.
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_ch.valid)
    else $error("result missing after a sample left the input register");

  // With the result side free, the input side must never stall.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_ch.ready) |-> in_ch.ready)
    else $error("input stalled while the result register was free");

  // The input stalls only when both registers hold a transaction.
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

FILE: tb/envelope_detector_with_gain_tracking_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for envelope_detector_with_gain_tracking_top.
// Uses edgt_pkg and the sample, result and register write channel interfaces.
// A built-in envelope and gain tracker predicts every result and checks it.

module envelope_detector_with_gain_tracking_top_test;
  import edgt_pkg::*;

  // Expected content of one result transaction.
  typedef struct packed {
    logic [ENV_W-1:0]  envelope;
    logic [GAIN_W-1:0] gain_level;
    logic              gain_rising;
  } env_result_t;

  localparam int IDLE_PCT       = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int RESET_CYCLES   = 7;

  // Register indexes that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst_n;
  bit   idling = 1'b1;

  edgt_in_if  in_ch();
  edgt_out_if out_ch();
  edgt_cfg_if cfg_ch();

  envelope_detector_with_gain_tracking_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker copy of the registers.
  logic [POLE_W-1:0]   pole_q;
  logic [TARGET_W-1:0] target_q;
  logic [GMAX_W-1:0]   gmax_q;
  logic [STEP_W-1:0]   up_q;
  logic [STEP_W-1:0]   down_q;

  // Tracker copy of the datapath state.
  logic [SAMPLE_W-1:0]        dc_x_prev;
  logic signed [DC_Y_W-1:0]   dc_y_prev;
  logic [GAIN_W-1:0]          gain_q;
  logic                       rising_q;
  logic [LEVEL_W-1:0]         lvl_hist [5];
  logic signed [FILT_Y_W-1:0] env_hist [4];

  env_result_t envelope_due [$];
  int errors = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_settings = 0;
  int quiet_cycles = 0;

  function automatic void reset_tracker();
    pole_q    = DC_POLE_RST;
    target_q  = AGC_TARGET_RST;
    gmax_q    = GAIN_MAX_RST;
    up_q      = GAIN_UP_STEP_RST;
    down_q    = GAIN_DOWN_STEP_RST;
    dc_x_prev = '0;
    dc_y_prev = '0;
    gain_q    = GAIN_RST;
    rising_q  = 1'b0;
    for (int i = 0; i < 5; i++) lvl_hist[i] = '0;
    for (int i = 0; i < 4; i++) env_hist[i] = '0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DC_POLE:        pole_q   = data[POLE_W-1:0];
      CFG_AGC_TARGET:     target_q = data[TARGET_W-1:0];
      CFG_GAIN_MAX:       gmax_q   = data[GMAX_W-1:0];
      CFG_GAIN_UP_STEP:   up_q     = data[STEP_W-1:0];
      CFG_GAIN_DOWN_STEP: down_q   = data[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // Floor division by 4096.
  function automatic longint floor_q12(longint v);
    return v >>> 12;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the tracker by one sample and returns the result it must produce.
  function automatic env_result_t track_sample(logic [SAMPLE_W-1:0] x);
    longint acc, y, lvl, f;
    env_result_t r;
    // DC blocker, saturated to 16 bits before it is stored.
    acc = 4095 * (longint'(x) - longint'(dc_x_prev))
        + longint'(pole_q) * longint'(dc_y_prev);
    y = clip(floor_q12(acc), -32768, 32767);
    dc_y_prev = y[DC_Y_W-1:0];
    dc_x_prev = x;

    // Rectify, saturating to the width of the filter input history.
    lvl = (y < 0) ? -y : y;
    if (lvl > 16383) lvl = 16383;

    // Gain tracking; a zero step still moves the direction flag.
    if (lvl < longint'(target_q)) begin
      if (gain_q < gmax_q) begin
        gain_q   = gain_q + up_q;
        rising_q = 1'b1;
      end
    end else if (gain_q > down_q) begin
      gain_q   = gain_q - down_q;
      rising_q = 1'b0;
    end

    // Butterworth low-pass on the history before the new level enters it.
    acc = 493 * (longint'(lvl_hist[0]) + longint'(lvl_hist[4]))
        + 1970 * (longint'(lvl_hist[1]) + longint'(lvl_hist[3]))
        + 2955 * longint'(lvl_hist[2])
        - 80 * longint'(env_hist[0])
        - 279 * longint'(env_hist[1])
        - 2122 * longint'(env_hist[2])
        - 1304 * longint'(env_hist[3]);
    f = clip(floor_q12(acc), -524288, 524287);

    for (int i = 0; i < 4; i++) lvl_hist[i] = lvl_hist[i+1];
    lvl_hist[4] = lvl[LEVEL_W-1:0];
    for (int i = 0; i < 3; i++) env_hist[i] = env_hist[i+1];
    env_hist[3] = f[FILT_Y_W-1:0];

    r.envelope    = ENV_W'(clip(f, 0, 4095));
    r.gain_level  = gain_q;
    r.gain_rising = rising_q;
    return r;
  endfunction

  // Result side: random back-pressure unless idling is off.
  always @(posedge clk) begin
    out_ch.ready <= !idling || ($urandom_range(99) >= IDLE_PCT);
  end

  // Tracks register writes and samples, checks results and guards against hangs.
  always @(posedge clk) begin
    env_result_t exp_r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (envelope_due.size() == 0) begin
          errors++;
          $display("%0t: result with no sample pending: envelope %0d gain %0d rising %0b",
                   $time, out_ch.envelope, out_ch.gain_level, out_ch.gain_rising);
        end else begin
          exp_r = envelope_due.pop_front();
          if (out_ch.envelope !== exp_r.envelope) begin
            errors++;
            $display("%0t: envelope expected %0d actual %0d",
                     $time, exp_r.envelope, out_ch.envelope);
          end
          if (out_ch.gain_level !== exp_r.gain_level) begin
            errors++;
            $display("%0t: gain_level expected %0d actual %0d",
                     $time, exp_r.gain_level, out_ch.gain_level);
          end
          if (out_ch.gain_rising !== exp_r.gain_rising) begin
            errors++;
            $display("%0t: gain_rising expected %0b actual %0b",
                     $time, exp_r.gain_rising, out_ch.gain_rising);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg_write(cfg_ch.index, cfg_ch.data);
        n_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        envelope_due.push_back(track_sample(in_ch.sample));
        n_samples++;
      end
    end

    // Watchdog on cycles without any transaction.
    if ((out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
        || (in_ch.valid && in_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, envelope_due.size());
      $display("envelope_detector_with_gain_tracking_top_test: done, errors");
      $finish;
    end
  end

  // Offers one sample after random gaps while idling, and waits for its transaction.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    if (idling) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stops the sample stream and waits until every result has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (envelope_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Writes every register with zero, its maximum or a random value.
  task automatic load_random_settings();
    logic [CFG_DATA_W-1:0] val, mask;
    int w;
    settle();
    for (int i = CFG_DC_POLE; i <= CFG_GAIN_DOWN_STEP; i++) begin
      case (i)
        CFG_DC_POLE:    w = POLE_W;
        CFG_AGC_TARGET: w = TARGET_W;
        CFG_GAIN_MAX:   w = GMAX_W;
        default:        w = STEP_W;
      endcase
      mask = CFG_DATA_W'((1 << w) - 1);
      case ($urandom_range(3))
        0:       val = '0;
        1:       val = mask;
        default: val = CFG_DATA_W'($urandom) & mask;
      endcase
      // Bits above the register width must be dropped.
      if ($urandom_range(3) == 0) val = val | (CFG_DATA_W'($urandom) & ~mask);
      write_reg(i[CFG_IDX_W-1:0], val);
    end
    if ($urandom_range(2) == 0) begin
      write_reg(CFG_IDX_W'(CFG_SPARE_FIRST + $urandom_range(2)), CFG_DATA_W'($urandom));
    end
    n_settings++;
  endtask

  // Sends a burst of samples shaped as noise, a square wave or a near-constant level.
  task automatic send_pattern(input int count);
    int pattern, lo, hi, period, noise, v;
    pattern = $urandom_range(3);
    lo      = $urandom_range(4095);
    hi      = $urandom_range(4095);
    period  = $urandom_range(1, 40);
    noise   = ($urandom_range(2) == 0) ? 128 : 0;
    for (int n = 0; n < count; n++) begin
      case (pattern)
        0: v = $urandom_range(4095);
        3: v = lo + int'($urandom_range(16)) - 8;
        default: begin
          v = ((n / period) % 2 == 1) ? hi : lo;
          if (noise != 0) v = v + int'($urandom_range(noise)) - noise / 2;
        end
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_sample(v[SAMPLE_W-1:0]);
    end
  endtask

  // Reset values, full-scale steps and alternating bit patterns.
  task automatic test_reset_settings();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd0);
    send_sample(12'd2048);
    send_sample(12'hAAA);
    send_sample(12'h555);
  endtask

  // Register extremes, zero steps, dropped upper bits and unknown indexes.
  task automatic test_register_extremes();
    settle();
    write_reg(CFG_DC_POLE, 13'h1FFF);
    write_reg(CFG_AGC_TARGET, 13'd0);
    write_reg(CFG_GAIN_MAX, 13'd0);
    write_reg(CFG_GAIN_UP_STEP, 13'd0);
    write_reg(CFG_GAIN_DOWN_STEP, 13'd0);
    write_reg(CFG_SPARE_FIRST, 13'h1FFF);
    write_reg(CFG_SPARE_LAST, 13'h1FFF);
    // Falls by a zero step.
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);

    settle();
    write_reg(CFG_AGC_TARGET, 13'h1FFF);
    write_reg(CFG_GAIN_MAX, 13'hFFF);
    // Rises by a zero step.
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd0);

    settle();
    write_reg(CFG_GAIN_UP_STEP, 13'hFF);
    write_reg(CFG_GAIN_DOWN_STEP, 13'hFF);
    send_sample(12'd1);
    send_sample(12'd4094);
    send_sample(12'd2);
    send_sample(12'd4093);

    settle();
    write_reg(CFG_AGC_TARGET, 13'd0);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd0);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      load_random_settings();
      send_pattern(per_phase / 2);
      send_pattern(per_phase - per_phase / 2);
    end
  endtask

  // A long stretch with both sides running at full rate.
  task automatic test_full_rate(input int count);
    load_random_settings();
    idling = 1'b0;
    send_pattern(count / 2);
    send_pattern(count - count / 2);
    idling = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    reset_tracker();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_settings();
    test_register_extremes();
    test_random_settings(8, 90);
    test_full_rate(200);
    settle();

    $display("Covered %0d samples and %0d results over %0d random register settings,",
             n_samples, n_results, n_settings);
    $display("with %0d register writes including unknown indexes and zero steps.", n_writes);
    if (errors == 0) begin
      $display("envelope_detector_with_gain_tracking_top_test: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("envelope_detector_with_gain_tracking_top_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: envelope_detector_with_gain_tracking_top.f
sv/edgt_pkg.sv
sv/edgt_in_if.sv
sv/edgt_out_if.sv
sv/edgt_cfg_if.sv
sv/edgt_dc_blocker.sv
sv/edgt_gain_tracker.sv
sv/edgt_bw_filter.sv
sv/envelope_detector_with_gain_tracking_top.sv
tb/envelope_detector_with_gain_tracking_top_test.sv
